// ===== rtl/tvd_pkg.sv =====
// shared types, trellis tables and helper function for the trellis viterbi decoder
package tvd_pkg;

  localparam int NUM_STATES   = 8;
  localparam int NUM_BRANCHES = 4;
  localparam int NUM_LEVELS   = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int DIST_BITS    = 12;
  localparam int PAIR_BITS    = 2;

  // renormalisation threshold, 10000 levels in q7.4
  localparam int unsigned RENORM_LIMIT = 160000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DIST_BITS-1:0]          dist_t;
  typedef logic [PAIR_BITS-1:0]          pair_t;
  typedef logic [2:0]                    state_idx_t;
  typedef logic [1:0]                    branch_idx_t;
  typedef logic [2:0]                    level_idx_t;
  typedef logic signed [SAMPLE_BITS:0]   level_val_t;

  // nominal level values, odd -7..7 scaled by 16
  localparam level_val_t LEVEL_VALUE [NUM_LEVELS] = '{
    -13'sd112, -13'sd80, -13'sd48, -13'sd16, 13'sd16, 13'sd48, 13'sd80, 13'sd112
  };

  // level index emitted for [state][branch]
  localparam level_idx_t LEVEL_OF [NUM_STATES][NUM_BRANCHES] = '{
    '{3'd0, 3'd2, 3'd0, 3'd2}, '{3'd0, 3'd2, 3'd0, 3'd2},
    '{3'd1, 3'd3, 3'd1, 3'd3}, '{3'd1, 3'd3, 3'd1, 3'd3},
    '{3'd4, 3'd6, 3'd4, 3'd6}, '{3'd4, 3'd6, 3'd4, 3'd6},
    '{3'd5, 3'd7, 3'd5, 3'd7}, '{3'd5, 3'd7, 3'd5, 3'd7}
  };

  // predecessor state for [state][branch]
  localparam state_idx_t PREV_OF [NUM_STATES][NUM_BRANCHES] = '{
    '{3'd0, 3'd2, 3'd4, 3'd6}, '{3'd2, 3'd0, 3'd6, 3'd4},
    '{3'd1, 3'd3, 3'd5, 3'd7}, '{3'd3, 3'd1, 3'd7, 3'd5},
    '{3'd4, 3'd6, 3'd0, 3'd2}, '{3'd6, 3'd4, 3'd2, 3'd0},
    '{3'd5, 3'd7, 3'd1, 3'd3}, '{3'd7, 3'd5, 3'd3, 3'd1}
  };

  // absolute distance between a sample and one nominal level
  function automatic dist_t level_dist(sample_t x, level_idx_t lv);
    level_val_t       diff;
    logic [SAMPLE_BITS:0] mag;
    diff = signed'({x[SAMPLE_BITS-1], x}) - LEVEL_VALUE[lv];
    mag  = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
    return mag[DIST_BITS-1:0];
  endfunction

endpackage

// ===== rtl/tvd_acs.sv =====
// add-compare-select unit with path metrics and register-exchange survivors
module tvd_acs
  import tvd_pkg::*;
#(
  parameter int SURVIVOR_SYMBOLS = 32,
  parameter int METRIC_BITS      = 20
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_en_i,
  input  sample_t sample_i,
  output pair_t   pair_o
);

  localparam int SurvBits = 2 * SURVIVOR_SYMBOLS;

  typedef logic [METRIC_BITS-1:0] metric_t;
  typedef logic [SurvBits-1:0]    surv_t;

  localparam metric_t MetricMax   = {METRIC_BITS{1'b1}};
  localparam metric_t RenormLimit = METRIC_BITS'(RENORM_LIMIT);

  metric_t     metric_q   [NUM_STATES];
  metric_t     metric_d   [NUM_STATES];
  surv_t       surv_q     [NUM_STATES];
  surv_t       surv_d     [NUM_STATES];
  dist_t       lvl_dist   [NUM_LEVELS];
  metric_t     cand       [NUM_STATES][NUM_BRANCHES];
  metric_t     acs_metric [NUM_STATES];
  branch_idx_t branch_sel [NUM_STATES];
  state_idx_t  best1_idx  [4];
  metric_t     best1_m    [4];
  state_idx_t  best2_idx  [2];
  metric_t     best2_m    [2];
  state_idx_t  win_state;
  metric_t     best_metric;
  logic        renorm;

  function automatic logic metric_le(metric_t a, metric_t b);
    return a <= b;
  endfunction

  // branch distances for all eight levels
  always_comb begin
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      lvl_dist[lv] = level_dist(sample_i, level_idx_t'(lv));
    end
  end

  // saturating candidate metrics
  always_comb begin
    logic [METRIC_BITS:0] sum;
    sum = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      for (int b = 0; b < NUM_BRANCHES; b++) begin
        sum = {1'b0, metric_q[PREV_OF[s][b]]} +
              (METRIC_BITS+1)'(lvl_dist[LEVEL_OF[s][b]]);
        cand[s][b] = sum[METRIC_BITS] ? MetricMax : sum[METRIC_BITS-1:0];
      end
    end
  end

  // compare-select, lowest branch wins a tie
  always_comb begin
    branch_idx_t lo_b, hi_b;
    metric_t     lo_m, hi_m;
    lo_b = '0;
    hi_b = '0;
    lo_m = '0;
    hi_m = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      lo_b = (cand[s][1] < cand[s][0]) ? 2'd1 : 2'd0;
      lo_m = (cand[s][1] < cand[s][0]) ? cand[s][1] : cand[s][0];
      hi_b = (cand[s][3] < cand[s][2]) ? 2'd3 : 2'd2;
      hi_m = (cand[s][3] < cand[s][2]) ? cand[s][3] : cand[s][2];
      branch_sel[s] = (hi_m < lo_m) ? hi_b : lo_b;
      acs_metric[s] = (hi_m < lo_m) ? hi_m : lo_m;
    end
  end

  // register exchange: decision enters at the top, predecessor path shifts down
  always_comb begin
    surv_t surv_sel;
    surv_sel = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      case (branch_sel[s])
        2'd0:    surv_sel = surv_q[PREV_OF[s][0]];
        2'd1:    surv_sel = surv_q[PREV_OF[s][1]];
        2'd2:    surv_sel = surv_q[PREV_OF[s][2]];
        2'd3:    surv_sel = surv_q[PREV_OF[s][3]];
        default: surv_sel = surv_q[PREV_OF[s][0]];
      endcase
      surv_d[s] = {branch_sel[s], surv_sel[SurvBits-1:2]};
    end
  end

  // best state tree, highest index wins a tie
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      best1_idx[i] = (metric_le(acs_metric[2*i+1], acs_metric[2*i])) ?
                     state_idx_t'(2*i+1) : state_idx_t'(2*i);
      best1_m[i]   = (metric_le(acs_metric[2*i+1], acs_metric[2*i])) ?
                     acs_metric[2*i+1] : acs_metric[2*i];
    end
    for (int i = 0; i < 2; i++) begin
      best2_idx[i] = (metric_le(best1_m[2*i+1], best1_m[2*i])) ?
                     best1_idx[2*i+1] : best1_idx[2*i];
      best2_m[i]   = (metric_le(best1_m[2*i+1], best1_m[2*i])) ?
                     best1_m[2*i+1] : best1_m[2*i];
    end
    win_state   = (metric_le(best2_m[1], best2_m[0])) ? best2_idx[1] : best2_idx[0];
    best_metric = (metric_le(best2_m[1], best2_m[0])) ? best2_m[1] : best2_m[0];
  end

  // renormalisation of all metrics by the best one when it exceeds the limit
  always_comb begin
    renorm = best_metric > RenormLimit;
    for (int s = 0; s < NUM_STATES; s++) begin
      metric_d[s] = renorm ? acs_metric[s] - best_metric : acs_metric[s];
    end
  end

  // oldest pair of the best survivor after this step
  assign pair_o = surv_d[win_state][PAIR_BITS-1:0];

  // trellis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metric_q[s] <= '0;
        surv_q[s]   <= '0;
      end
    end else if (step_en_i) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metric_q[s] <= metric_d[s];
        surv_q[s]   <= surv_d[s];
      end
    end
  end

`ifndef SYNTHESIS
  // renormalised step leaves the best state at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && renorm |=> metric_q[$past(win_state)] == '0)
    else $error("best metric not zero after renormalisation");

  // plain step keeps the best metric as selected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && !renorm |=> metric_q[$past(win_state)] == $past(best_metric))
    else $error("best metric lost on update");

  // metric and survivor of state 0 hold while no step is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(metric_q[0]) && $stable(surv_q[0]))
    else $error("trellis state changed without a step");
`endif

endmodule

// ===== rtl/trellis_viterbi_8state_decoder.sv =====
// top level of the 8-state soft-decision trellis viterbi decoder
//
// usage:
//   input channel in_valid_i / in_stall_o carries one q7.4 soft sample per
//   transfer on soft_sample_i; output channel out_valid_o / out_stall_i
//   carries one decoded bit pair per transfer on decided_pair_o.
//   every input sample gives exactly one output pair, in order.
// path: a sample taken into the input register passes the add-compare-select
//   step into the result register, which drives decided_pair_o.
// throughput: one sample per cycle while the output is not stalled; the
//   add-compare-select step for all eight states, the best-state search and
//   renormalisation are combinational around the path metric registers.
// stall: the result register holds its pair while out_stall_i is high; one
//   further sample waits in the input register, after which in_stall_o rises
//   until the result is taken.
// reset: rst_ni clears path metrics, survivors and both valid flags; the
//   block is ready for a sample as soon as reset is released.
module trellis_viterbi_8state_decoder
  import tvd_pkg::*;
#(
  parameter int SURVIVOR_SYMBOLS = 32,
  parameter int METRIC_BITS      = 20
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  sample_t soft_sample_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output pair_t   decided_pair_o
);

  logic    sample_valid_q, sample_valid_d;
  sample_t sample_q, sample_d;
  logic    out_valid_q, out_valid_d;
  pair_t   pair_q, pair_d;
  pair_t   acs_pair;
  logic    acs_fire;
  logic    in_take;

  // handshake control
  assign acs_fire   = sample_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = sample_valid_q && !acs_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  // next values of the input and result stages
  always_comb begin
    sample_valid_d = in_take || (sample_valid_q && !acs_fire);
    sample_d       = in_take ? soft_sample_i : sample_q;
    out_valid_d    = acs_fire || (out_valid_q && out_stall_i);
    pair_d         = acs_fire ? acs_pair : pair_q;
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      sample_valid_q <= sample_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    pair_q   <= pair_d;
  end

  tvd_acs #(
    .SURVIVOR_SYMBOLS(SURVIVOR_SYMBOLS),
    .METRIC_BITS     (METRIC_BITS)
  ) u_acs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(acs_fire),
    .sample_i (sample_q),
    .pair_o   (acs_pair)
  );

  assign out_valid_o    = out_valid_q;
  assign decided_pair_o = pair_q;

`ifndef SYNTHESIS
  // pending sample kept while the result is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_q && out_valid_q && out_stall_i |=> sample_valid_q)
    else $error("pending sample dropped under output stall");

  // every trellis step produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acs_fire |=> out_valid_q)
    else $error("trellis step without result");

  // an input transfer lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> sample_valid_q)
    else $error("accepted sample not captured");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the 8-state soft-decision trellis viterbi decoder
`timescale 1ns / 100ps

module tb_top
  import tvd_pkg::*;
();

  localparam int TRACEBACK      = 32;
  localparam int COST_BITS      = 20;
  localparam int unsigned RESCALE_THRESHOLD = 160000;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1825;
  localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTS     = 40;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t soft_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  pair_t   decided_pair;

  // trellis tables: level sent and predecessor for [state][branch]
  int unsigned emit_level [8][4] = '{
    '{0, 2, 0, 2}, '{0, 2, 0, 2}, '{1, 3, 1, 3}, '{1, 3, 1, 3},
    '{4, 6, 4, 6}, '{4, 6, 4, 6}, '{5, 7, 5, 7}, '{5, 7, 5, 7}
  };
  int unsigned from_state [8][4] = '{
    '{0, 2, 4, 6}, '{2, 0, 6, 4}, '{1, 3, 5, 7}, '{3, 1, 7, 5},
    '{4, 6, 0, 2}, '{6, 4, 2, 0}, '{5, 7, 1, 3}, '{7, 5, 3, 1}
  };

  // decoder state mirrored by the predictor
  int unsigned state_cost [8];
  logic [63:0] state_path [8];

  sample_t sample_queue [$];
  pair_t   expected_pairs [$];

  int   samples_taken = 0;
  int   pairs_taken = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   send_gap = 0;
  int   hold_left = 0;

  trellis_viterbi_8state_decoder uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .soft_sample_i  (soft_sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .decided_pair_o (decided_pair)
  );

  // clock
  always #5 clk = ~clk;

  // one add-compare-select step, returns the oldest pair of the best survivor
  task automatic viterbi_step(input sample_t x, output pair_t pair);
    int unsigned lvl_dist [8];
    int unsigned next_cost [8];
    logic [63:0] next_path [8];
    int unsigned cost_max, cand, best_cand, best_cost;
    int          diff, best_br, win_state;
    cost_max   = (32'd1 << COST_BITS) - 1;
    best_cost  = 0;
    win_state  = 0;
    for (int lv = 0; lv < 8; lv++) begin
      diff         = int'(x) - (2 * lv - 7) * 16;
      lvl_dist[lv] = (diff < 0) ? -diff : diff;
    end
    for (int s = 0; s < 8; s++) begin
      best_cand = 0;
      best_br   = 0;
      // lowest branch wins a tie
      for (int b = 0; b < 4; b++) begin
        cand = lvl_dist[emit_level[s][b]] + state_cost[from_state[s][b]];
        if (cand > cost_max) cand = cost_max;
        if (b == 0 || cand < best_cand) begin
          best_cand = cand;
          best_br   = b;
        end
      end
      next_cost[s] = best_cand;
      next_path[s] = (state_path[from_state[s][best_br]] >> 2) |
                     (64'(best_br) << (2 * TRACEBACK - 2));
      // highest state wins a tie
      if (s == 0 || best_cand <= best_cost) begin
        best_cost = best_cand;
        win_state = s;
      end
    end
    // renormalisation against the best metric
    for (int s = 0; s < 8; s++) begin
      if (best_cost > RESCALE_THRESHOLD) next_cost[s] -= best_cost;
      state_cost[s] = next_cost[s] & cost_max;
      state_path[s] = next_path[s];
    end
    pair = state_path[win_state][1:0];
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at pair %0d: %s, got %0d, expected %0d", pairs_taken, what, got, want);
    mismatches++;
  endtask

  // wait per item, with stretches of no idling
  function automatic int pick_wait(input int n);
    return ((n / 150) % 3 == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  // random sample: mostly noisy nominal levels, then anything, then the rails
  function automatic sample_t random_sample();
    int pick, lv;
    pick = $urandom_range(0, 99);
    lv   = $urandom_range(0, 7);
    if (pick < 65) return 12'((2 * lv - 7) * 16 + $urandom_range(0, 80) - 40);
    else if (pick < 88) return 12'($urandom);
    else if (pick < 94) return 12'(-2048 + $urandom_range(0, 63));
    else return 12'(2047 - $urandom_range(0, 63));
  endfunction

  // predictor and checker on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pair_t predicted;
        viterbi_step(soft_sample, predicted);
        expected_pairs.push_back(predicted);
        samples_taken++;
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("pair with no sample pending", int'(decided_pair), 0);
        end else begin
          pair_t want;
          want = expected_pairs.pop_front();
          if (decided_pair !== want)
            report_mismatch("decided_pair", int'(decided_pair), int'(want));
        end
        pairs_taken++;
      end
      in_took  <= (in_valid === 1'b1 && in_stall === 1'b0);
      out_took <= (out_valid === 1'b1 && out_stall === 1'b0);
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_valid && !in_took)) begin
        if (in_took) send_gap = pick_wait(samples_taken + 60);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_valid    <= 1'b1;
          soft_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pair receiver, with long hold-offs that back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        if (pairs_taken == 300 || pairs_taken == 1200) hold_left = $urandom_range(150, 250);
        else hold_left = pick_wait(pairs_taken);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("trellis_viterbi_8state_decoder verification failed");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    sample_t directed [DIRECTED_ITEMS];
    for (int s = 0; s < 8; s++) begin
      state_cost[s] = 0;
      state_path[s] = '0;
    end
    // rails, zero crossing, every nominal level, midpoints and toggling patterns
    directed = '{
      -12'sd2048, 12'sd2047, 12'sd0, -12'sd1, 12'sd1,
      -12'sd112, -12'sd80, -12'sd48, -12'sd16, 12'sd16, 12'sd48, 12'sd80, 12'sd112,
      -12'sd96, -12'sd64, -12'sd32, 12'sd32, 12'sd64, 12'sd96,
      -12'sd128, 12'sd127, 12'sd1365, -12'sd1366, 12'sd2047, -12'sd2048
    };
    foreach (directed[i]) sample_queue.push_back(directed[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) sample_queue.push_back(random_sample());

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!(samples_taken == TOTAL_ITEMS && pairs_taken == TOTAL_ITEMS)) @(negedge clk);
    repeat (8) @(negedge clk);
    while (expected_pairs.size() > 0) begin
      report_mismatch("pair never delivered", 0, int'(expected_pairs.pop_front()));
    end

    if (mismatches == 0) begin
      $display("trellis_viterbi_8state_decoder verification clean");
    end else begin
      $display("trellis_viterbi_8state_decoder verification failed");
    end
    $finish;
  end

endmodule
